[rtl/zcrms_pkg.sv]
`default_nettype none
package zcrms_pkg;

  localparam int NCH   = 6;
  localparam int CH_W  = 3;
  localparam int OUT_W = 16;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_GRID   = 2'd1;
  localparam logic [1:0] FUNC_INV    = 2'd2;

  localparam logic [NCH-1:0] MASK_RESET = 6'd60;

  typedef struct packed {
    logic add;
    logic close;
    logic ack;
  } lane_cmd_t;

endpackage
`default_nettype wire

[rtl/zero_cross_true_rms_meter.sv]
`default_nettype none
// Six-channel true-RMS meter. A sample word (func 0) adds each channel's
// squared sample to that channel's lane: the square is registered first,
// then accumulated. A grid or inverter window-end word closes the channels
// of its group, chosen by the inverter group mask; every closing lane runs
// its own restoring divider on a SUM_W-bit sum, one quotient bit per cycle
// (SUM_W = 2*SAMPLE_BITS-2+COUNT_BITS, at most 64, 46 by default), then a
// square root unit, one root bit per cycle for SUM_W/2 bits rounded up (23).
// A channel with an empty window finishes at once with an RMS of zero.
// Results leave in ascending channel order with last set on the final one.
// The next input word is taken once the previous one's results have all
// been handed to the output register.
module zero_cross_true_rms_meter #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [zcrms_pkg::NCH-1:0]     cfg_inverter_group_mask,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_func,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_0,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_1,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_2,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_3,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_4,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_5,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [zcrms_pkg::CH_W-1:0]         out_channel,
  output logic [zcrms_pkg::OUT_W-1:0]        out_rms_value,
  output logic [zcrms_pkg::OUT_W-1:0]        out_sample_count,
  output logic                               out_count_saturated,
  output logic                               out_last
);

  logic [zcrms_pkg::NCH-1:0]   mask_r;
  logic                        add_busy_r;
  logic                        accept;
  logic                        merge_busy;
  logic [zcrms_pkg::NCH-1:0]   close_vec;
  logic [zcrms_pkg::NCH-1:0]   ack_vec;
  logic [zcrms_pkg::NCH-1:0]   done_vec;
  logic [zcrms_pkg::NCH-1:0]   sat_vec;
  logic [SAMPLE_BITS-1:0]      smp [zcrms_pkg::NCH];
  logic [zcrms_pkg::OUT_W-1:0] rms_vec [zcrms_pkg::NCH];
  logic [zcrms_pkg::OUT_W-1:0] cnt_vec [zcrms_pkg::NCH];
  zcrms_pkg::lane_cmd_t        cmd [zcrms_pkg::NCH];

  assign cfg_ready = 1'b1;
  assign in_ready  = !add_busy_r && !merge_busy;
  assign accept    = in_valid && in_ready;

  assign smp[0] = in_sample_0;
  assign smp[1] = in_sample_1;
  assign smp[2] = in_sample_2;
  assign smp[3] = in_sample_3;
  assign smp[4] = in_sample_4;
  assign smp[5] = in_sample_5;

  always_comb begin
    close_vec = '0;
    if (accept && in_func == zcrms_pkg::FUNC_GRID) begin
      close_vec = ~mask_r;
    end else if (accept && in_func == zcrms_pkg::FUNC_INV) begin
      close_vec = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= zcrms_pkg::MASK_RESET;
      add_busy_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mask_r <= cfg_inverter_group_mask;
      end
      add_busy_r <= accept && (in_func == zcrms_pkg::FUNC_SAMPLE);
    end
  end

  for (genvar g = 0; g < zcrms_pkg::NCH; g++) begin : g_lane
    assign cmd[g] = zcrms_pkg::lane_cmd_t'{
      add:   accept && (in_func == zcrms_pkg::FUNC_SAMPLE),
      close: close_vec[g],
      ack:   ack_vec[g]
    };

    zcrms_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[g]),
      .smp   (smp[g]),
      .done  (done_vec[g]),
      .rms_o (rms_vec[g]),
      .cnt_o (cnt_vec[g]),
      .sat_o (sat_vec[g])
    );
  end

  zcrms_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (close_vec),
    .done                (done_vec),
    .rms_i               (rms_vec),
    .cnt_i               (cnt_vec),
    .sat_i               (sat_vec),
    .ack                 (ack_vec),
    .busy                (merge_busy),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_channel         (out_channel),
    .out_rms_value       (out_rms_value),
    .out_sample_count    (out_sample_count),
    .out_count_saturated (out_count_saturated),
    .out_last            (out_last)
  );

endmodule
`default_nettype wire

[rtl/zcrms_lane.sv]
`default_nettype none
module zcrms_lane #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire zcrms_pkg::lane_cmd_t         cmd,
  input  wire logic [SAMPLE_BITS-1:0]       smp,
  output logic                              done,
  output logic [zcrms_pkg::OUT_W-1:0]       rms_o,
  output logic [zcrms_pkg::OUT_W-1:0]       cnt_o,
  output logic                              sat_o
);

  localparam int RAW_W  = 2*SAMPLE_BITS - 2 + COUNT_BITS;
  localparam int SUM_W  = (RAW_W > 64) ? 64 : RAW_W;
  localparam int SQ_W   = SUM_W + (SUM_W % 2);
  localparam int ROOT_W = SQ_W / 2;
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int RMS_X  = (ROOT_W > zcrms_pkg::OUT_W) ? ROOT_W : zcrms_pkg::OUT_W;
  localparam int CNT_X  = (COUNT_BITS > zcrms_pkg::OUT_W) ? COUNT_BITS : zcrms_pkg::OUT_W;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_DIV  = 2'd1;
  localparam logic [1:0] L_SQRT = 2'd2;
  localparam logic [1:0] L_DONE = 2'd3;

  logic [1:0]              st_r;
  logic                    add_r;
  logic [STEP_W-1:0]       step_r;
  logic [2*SAMPLE_BITS-1:0] sq_r;
  logic [SUM_W-1:0]        sum_r;
  logic [COUNT_BITS-1:0]   cnt_r;
  logic                    sat_r;
  logic [COUNT_BITS-1:0]   cnt_o_r;
  logic                    sat_o_r;
  logic [SUM_W-1:0]        dvd_r;
  logic [COUNT_BITS-1:0]   div_r;
  logic [COUNT_BITS-1:0]   rem_r;
  logic [SQ_W-1:0]         opnd_r;
  logic [ROOT_W:0]         rem2_r;
  logic [ROOT_W-1:0]       root_r;

  logic [SAMPLE_BITS-1:0]  mag;
  logic [SUM_W:0]          sum_add;
  logic [COUNT_BITS:0]     rem_sh;
  logic [COUNT_BITS:0]     rem_diff;
  logic                    q_bit;
  logic [SUM_W-1:0]        quot_nxt;
  logic [ROOT_W+2:0]       rem2_sh;
  logic [ROOT_W+2:0]       trial;
  logic [ROOT_W+2:0]       rem2_diff;
  logic                    r_bit;
  logic [RMS_X-1:0]        rms_x;
  logic [CNT_X-1:0]        cnt_x;

  always_comb begin
    mag       = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
    sum_add   = {1'b0, sum_r} + (SUM_W+1)'(sq_r);
    rem_sh    = {rem_r, dvd_r[SUM_W-1]};
    rem_diff  = rem_sh - {1'b0, div_r};
    q_bit     = (rem_sh >= {1'b0, div_r});
    quot_nxt  = {dvd_r[SUM_W-2:0], q_bit};
    rem2_sh   = {rem2_r, opnd_r[SQ_W-1 -: 2]};
    trial     = {1'b0, root_r, 2'b01};
    rem2_diff = rem2_sh - trial;
    r_bit     = (rem2_sh >= trial);
    rms_x     = RMS_X'(root_r);
    cnt_x     = CNT_X'(cnt_o_r);
  end

  assign done  = (st_r == L_DONE);
  assign rms_o = rms_x[zcrms_pkg::OUT_W-1:0];
  assign cnt_o = cnt_x[zcrms_pkg::OUT_W-1:0];
  assign sat_o = sat_o_r;

  // Accumulator and sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      add_r  <= 1'b0;
      sum_r  <= '0;
      cnt_r  <= '0;
      sat_r  <= 1'b0;
      step_r <= '0;
    end else begin
      add_r <= cmd.add;
      if (add_r) begin
        if (cnt_r == {COUNT_BITS{1'b1}}) begin
          sat_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          // The sum sticks at all ones if it would overflow.
          sum_r <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        end
      end
      unique case (st_r)
        L_IDLE: begin
          if (cmd.close) begin
            sum_r  <= '0;
            cnt_r  <= '0;
            sat_r  <= 1'b0;
            step_r <= '0;
            st_r   <= (cnt_r == '0) ? L_DONE : L_DIV;
          end
        end
        L_DIV: begin
          if (step_r == STEP_W'(SUM_W-1)) begin
            step_r <= '0;
            st_r   <= L_SQRT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        L_SQRT: begin
          if (step_r == STEP_W'(ROOT_W-1)) begin
            step_r <= '0;
            st_r   <= L_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        L_DONE: begin
          if (cmd.ack) begin
            st_r <= L_IDLE;
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  // Datapath: square, restoring division, then digit-by-digit square root.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      sq_r <= mag * mag;
    end
    unique case (st_r)
      L_IDLE: begin
        if (cmd.close) begin
          cnt_o_r <= cnt_r;
          sat_o_r <= sat_r;
          dvd_r   <= sum_r;
          div_r   <= cnt_r;
          rem_r   <= '0;
          root_r  <= '0;
        end
      end
      L_DIV: begin
        rem_r <= q_bit ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        dvd_r <= quot_nxt;
        if (step_r == STEP_W'(SUM_W-1)) begin
          opnd_r <= SQ_W'(quot_nxt);
          rem2_r <= '0;
          root_r <= '0;
        end
      end
      L_SQRT: begin
        rem2_r <= r_bit ? rem2_diff[ROOT_W:0] : rem2_sh[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], r_bit};
        opnd_r <= {opnd_r[SQ_W-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/zcrms_merge.sv]
`default_nettype none
module zcrms_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [zcrms_pkg::NCH-1:0]   start,
  input  wire logic [zcrms_pkg::NCH-1:0]   done,
  input  wire logic [zcrms_pkg::OUT_W-1:0] rms_i [zcrms_pkg::NCH],
  input  wire logic [zcrms_pkg::OUT_W-1:0] cnt_i [zcrms_pkg::NCH],
  input  wire logic [zcrms_pkg::NCH-1:0]   sat_i,
  output logic [zcrms_pkg::NCH-1:0]        ack,
  output logic                             busy,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [zcrms_pkg::CH_W-1:0]       out_channel,
  output logic [zcrms_pkg::OUT_W-1:0]      out_rms_value,
  output logic [zcrms_pkg::OUT_W-1:0]      out_sample_count,
  output logic                             out_count_saturated,
  output logic                             out_last
);

  logic [zcrms_pkg::NCH-1:0]   pend_r;
  logic                        valid_r;
  logic [zcrms_pkg::CH_W-1:0]  ch_r;
  logic [zcrms_pkg::OUT_W-1:0] rms_r;
  logic [zcrms_pkg::OUT_W-1:0] cnt_r;
  logic                        sat_r;
  logic                        last_r;

  logic [zcrms_pkg::NCH-1:0]   sel;
  logic [zcrms_pkg::CH_W-1:0]  idx;
  logic                        fire;

  // Lowest pending channel goes out first.
  always_comb begin
    sel = pend_r & (~pend_r + 1'b1);
    idx = '0;
    for (int i = 0; i < zcrms_pkg::NCH; i++) begin
      if (sel[i]) begin
        idx = zcrms_pkg::CH_W'(i);
      end
    end
    fire = (pend_r != '0) && ((done & sel) != '0) && (!valid_r || out_ready);
  end

  assign ack                 = fire ? sel : '0;
  assign busy                = (pend_r != '0);
  assign out_valid           = valid_r;
  assign out_channel         = ch_r;
  assign out_rms_value       = rms_r;
  assign out_sample_count    = cnt_r;
  assign out_count_saturated = sat_r;
  assign out_last            = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (fire) begin
        pend_r  <= pend_r & ~sel;
        valid_r <= 1'b1;
      end else begin
        pend_r <= pend_r | start;
        if (out_ready) begin
          valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ch_r   <= idx;
      rms_r  <= rms_i[idx];
      cnt_r  <= cnt_i[idx];
      sat_r  <= sat_i[idx];
      last_r <= ((pend_r & ~sel) == '0);
    end
  end

endmodule
`default_nettype wire

[sim/zero_cross_true_rms_meter_test.sv]
module zero_cross_true_rms_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int COUNT_FULL = 65535;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [zcrms_pkg::CH_W-1:0]  channel;
    logic [zcrms_pkg::OUT_W-1:0] rms_value;
    logic [zcrms_pkg::OUT_W-1:0] sample_count;
    logic                        count_saturated;
    logic                        last;
  } rms_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [zcrms_pkg::NCH-1:0] cfg_inverter_group_mask = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = zcrms_pkg::FUNC_SAMPLE;
  logic signed [15:0] in_sample_0 = '0;
  logic signed [15:0] in_sample_1 = '0;
  logic signed [15:0] in_sample_2 = '0;
  logic signed [15:0] in_sample_3 = '0;
  logic signed [15:0] in_sample_4 = '0;
  logic signed [15:0] in_sample_5 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [zcrms_pkg::CH_W-1:0] out_channel;
  logic [zcrms_pkg::OUT_W-1:0] out_rms_value;
  logic [zcrms_pkg::OUT_W-1:0] out_sample_count;
  logic out_count_saturated;
  logic out_last;

  // Predicted meter state.
  logic [63:0] sum_of_squares [zcrms_pkg::NCH];
  int unsigned samples_in_window [zcrms_pkg::NCH];
  logic dropped_flag [zcrms_pkg::NCH];
  logic [zcrms_pkg::NCH-1:0] inverter_mask;

  logic signed [15:0] next_samples [zcrms_pkg::NCH];
  rms_result_t pending_rms[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int errors = 0;
  int quiet_cycles = 0;

  zero_cross_true_rms_meter dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_inverter_group_mask(cfg_inverter_group_mask),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_sample_0(in_sample_0),
    .in_sample_1(in_sample_1),
    .in_sample_2(in_sample_2),
    .in_sample_3(in_sample_3),
    .in_sample_4(in_sample_4),
    .in_sample_5(in_sample_5),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_channel(out_channel),
    .out_rms_value(out_rms_value),
    .out_sample_count(out_sample_count),
    .out_count_saturated(out_count_saturated),
    .out_last(out_last)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic predict_word(input logic [1:0] f);
    logic [63:0] mag;
    bit closes;
    rms_result_t r;
    int n;
    n = 0;
    if (f == zcrms_pkg::FUNC_SAMPLE) begin
      for (int c = 0; c < zcrms_pkg::NCH; c++) begin
        mag = (next_samples[c] < 0) ? 64'(-longint'(next_samples[c]))
                                    : 64'(longint'(next_samples[c]));
        if (samples_in_window[c] >= COUNT_FULL) begin
          dropped_flag[c] = 1'b1;
        end else begin
          samples_in_window[c]++;
          sum_of_squares[c] += mag * mag;
        end
      end
    end else if (f != FUNC_NONE) begin
      for (int c = 0; c < zcrms_pkg::NCH; c++) begin
        closes = (f == zcrms_pkg::FUNC_INV) ? inverter_mask[c] : !inverter_mask[c];
        if (closes) begin
          r.channel = zcrms_pkg::CH_W'(c);
          r.rms_value = (samples_in_window[c] == 0) ? '0 :
            zcrms_pkg::OUT_W'(floor_root(sum_of_squares[c] / samples_in_window[c]));
          r.sample_count = zcrms_pkg::OUT_W'(samples_in_window[c]);
          r.count_saturated = dropped_flag[c];
          r.last = 1'b0;
          pending_rms.push_back(r);
          sum_of_squares[c] = 0;
          samples_in_window[c] = 0;
          dropped_flag[c] = 1'b0;
          n++;
        end
      end
      if (n > 0) begin
        pending_rms[$].last = 1'b1;
      end
    end
  endtask

  task automatic send_word(input logic [1:0] f);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) begin
      gap++;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= f;
    in_sample_0 <= next_samples[0];
    in_sample_1 <= next_samples[1];
    in_sample_2 <= next_samples[2];
    in_sample_3 <= next_samples[3];
    in_sample_4 <= next_samples[4];
    in_sample_5 <= next_samples[5];
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_word(f);
  endtask

  task automatic send_samples_all(input logic signed [15:0] v);
    for (int c = 0; c < zcrms_pkg::NCH; c++) begin
      next_samples[c] = v;
    end
    send_word(zcrms_pkg::FUNC_SAMPLE);
  endtask

  task automatic send_random_word();
    int k;
    k = $urandom_range(0, 99);
    for (int c = 0; c < zcrms_pkg::NCH; c++) begin
      next_samples[c] = pick_sample();
    end
    if (k < 76) begin
      send_word(zcrms_pkg::FUNC_SAMPLE);
    end else if (k < 87) begin
      send_word(zcrms_pkg::FUNC_GRID);
    end else if (k < 98) begin
      send_word(zcrms_pkg::FUNC_INV);
    end else begin
      send_word(FUNC_NONE);
    end
  endtask

  // Waits for every predicted result, then lets a divide and root finish.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_rms.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [zcrms_pkg::NCH-1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_inverter_group_mask <= m;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    inverter_mask = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_windows();
    send_word(zcrms_pkg::FUNC_GRID);
    send_word(zcrms_pkg::FUNC_INV);
    send_word(FUNC_NONE);
  endtask

  task automatic test_sample_extremes();
    send_samples_all(16'sh8000);
    send_samples_all(16'sh7fff);
    send_samples_all(16'sh0000);
    send_samples_all(-16'sd1);
    send_samples_all(16'sd1);
    next_samples = '{16'sh8000, 16'sh7fff, 16'sh5555, -16'sd21846, 16'sd3, -16'sd3};
    send_word(zcrms_pkg::FUNC_SAMPLE);
    send_word(FUNC_NONE);
    send_word(zcrms_pkg::FUNC_GRID);
    send_word(zcrms_pkg::FUNC_INV);
    write_mask(6'd0);
    send_samples_all(16'sd100);
    send_word(zcrms_pkg::FUNC_INV);
    send_word(zcrms_pkg::FUNC_GRID);
    write_mask(6'd63);
    send_samples_all(-16'sd200);
    send_word(zcrms_pkg::FUNC_GRID);
    send_word(zcrms_pkg::FUNC_INV);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [zcrms_pkg::NCH-1:0] m, input int n);
    write_mask(m);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      send_random_word();
    end
  endtask

  task automatic test_output_backpressure();
    write_mask(6'($urandom_range(1, 62)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 400;
    for (int i = 0; i < 30; i++) begin
      send_random_word();
    end
    // The sender waits here until every result is out.
    drain();
  endtask

  always @(negedge clk) begin
    int hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    rms_result_t want;
    rms_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_channel, out_rms_value, out_sample_count, out_count_saturated, out_last};
      if (pending_rms.size() == 0) begin
        $display("%0t: unexpected result word, actual %p", $time, got);
        errors++;
      end else begin
        want = pending_rms.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < zcrms_pkg::NCH; c++) begin
      sum_of_squares[c] = 0;
      samples_in_window[c] = 0;
      dropped_flag[c] = 1'b0;
      next_samples[c] = 0;
    end
    inverter_mask = zcrms_pkg::MASK_RESET;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_windows();
    test_sample_extremes();
    test_random_phase(0, 0, 6'($urandom_range(0, 63)), 90);
    test_random_phase(47, 0, 6'($urandom_range(0, 63)), 90);
    test_random_phase(0, 47, 6'($urandom_range(0, 63)), 90);
    test_random_phase(16, 16, zcrms_pkg::MASK_RESET, 90);
    test_output_backpressure();
    drain();
    if (errors == 0 && pending_rms.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
